// File: src/dvst_pkg.sv
package dvst_pkg;

  // Request codes; code 3 behaves as a lookup.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DUPLICATE = 2'd1;
  localparam logic [1:0] STAT_ABSENT    = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam int unsigned ValueW = 64;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // Per-cell controls driven by the top level.
  typedef struct packed {
    logic cmp;    // compare stored word against key
    logic valid;  // cell holds a live entry
    logic shift;  // take neighbor's word (remove)
    logic load;   // take key word (append)
  } cell_ctl_t;

endpackage

// File: src/dvst_req_if.sv
interface dvst_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [dvst_pkg::ValueW-1:0]     value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// File: src/dvst_rsp_if.sv
interface dvst_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] position;
  logic [4:0] entries_now;

  modport source (output valid, output status, output position, output entries_now,
                  input ready);
  modport sink   (input valid, input status, input position, input entries_now,
                  output ready);
endinterface

// File: src/dvst_cell.sv
module dvst_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dvst_pkg::cell_ctl_t           ctl_i,
  input  logic [dvst_pkg::ValueW-1:0]   key_i,
  input  logic [dvst_pkg::ValueW-1:0]   next_value_i,
  output logic [dvst_pkg::ValueW-1:0]   value_o,
  output logic                          hit_o
);

  logic [dvst_pkg::ValueW-1:0] value_q, value_d;
  logic                        hit_q, hit_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.load) begin
      value_d = key_i;
    end else if (ctl_i.shift) begin
      value_d = next_value_i;
    end
    hit_d = hit_q;
    if (ctl_i.cmp) begin
      hit_d = ctl_i.valid && (value_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// File: src/distinct_value_set_table_unit.sv
// Distinct value set table: a packed list of distinct 64-bit words kept in
// insertion order, held in a row of CAPACITY cells.
// Request channel (req_i): req_type 0 lookup, 1 add, 2 remove (3 acts as
// lookup) plus the 64-bit value. Response channel (rsp_o): status, position
// and entries_now, exactly one item per request.
// In the accept cycle every cell compares its word against the incoming
// value in parallel and registers a hit flag. In the update state that
// follows, the hit position is encoded, the response register is loaded
// and the row is updated: an add writes the cell at the fill count, a
// remove makes every cell at or above the hit take its upper neighbor's
// word. The update cycle waits while the response register still holds an
// unclaimed item; no new request is taken until the update is done, so
// items are processed one at a time and a stall holds the row unchanged.
// Reset clears the fill count, handshake state and the cells' hit flags;
// cell words stay undefined until written and are never read above the
// fill count.
module distinct_value_set_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dvst_req_if.sink   req_i,
  dvst_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  dvst_pkg::state_e state_q, state_d;

  logic [1:0]                    req_type_q;
  logic [dvst_pkg::ValueW-1:0]   key_q;
  logic [dvst_pkg::ValueW-1:0]   key_bus;
  logic [CntW-1:0]               count_q, count_d;

  logic                          rsp_valid_q, rsp_valid_d;
  logic [1:0]                    rsp_status_q, rsp_status_d;
  logic [3:0]                    rsp_pos_q, rsp_pos_d;
  logic [4:0]                    rsp_cnt_q, rsp_cnt_d;

  logic                          accept;
  logic                          go;       // update cycle may commit
  logic                          do_add;   // append key at fill count
  logic                          do_rem;   // compact from hit position

  logic [CAPACITY-1:0]           hit;
  logic [dvst_pkg::ValueW-1:0]   cell_value [CAPACITY];
  logic                          hit_any;
  logic [IdxW-1:0]               hit_pos;
  logic [IdxW-1:0]               res_pos;
  logic [IdxW+3:0]               pos_ext;
  logic [CntW+4:0]               cnt_ext;

  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == dvst_pkg::ST_IDLE);
  assign go        = (state_q == dvst_pkg::ST_UPDATE) && (!rsp_valid_q || rsp_o.ready);

  // Compare against the port value in the accept cycle, write the held key later.
  assign key_bus = (state_q == dvst_pkg::ST_IDLE) ? req_i.value : key_q;

  // At most one live cell can hit since stored words are distinct, so an
  // OR of the matching indices gives the position.
  always_comb begin
    hit_any = |hit;
    hit_pos = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      if (hit[k]) begin
        hit_pos = hit_pos | IdxW'(k);
      end
    end
  end

  // Response and state update decisions.
  always_comb begin
    do_add       = 1'b0;
    do_rem       = 1'b0;
    count_d      = count_q;
    res_pos      = '0;
    rsp_status_d = dvst_pkg::STAT_OK;
    unique case (req_type_q)
      dvst_pkg::REQ_ADD: begin
        if (hit_any) begin
          rsp_status_d = dvst_pkg::STAT_DUPLICATE;
        end else if (count_q >= CapCnt) begin
          rsp_status_d = dvst_pkg::STAT_FULL;
        end else begin
          res_pos = count_q[IdxW-1:0];
          do_add  = go;
          count_d = go ? count_q + CntW'(1) : count_q;
        end
      end
      dvst_pkg::REQ_REMOVE: begin
        if (!hit_any) begin
          rsp_status_d = dvst_pkg::STAT_ABSENT;
        end else begin
          res_pos = hit_pos;
          do_rem  = go;
          count_d = go ? count_q - CntW'(1) : count_q;
        end
      end
      default: begin
        if (hit_any) begin
          res_pos = hit_pos;
        end else begin
          rsp_status_d = dvst_pkg::STAT_ABSENT;
        end
      end
    endcase
  end

  // Position and count are reported masked to the field widths.
  assign pos_ext = {4'b0, res_pos};
  assign cnt_ext = {5'b0, count_d};

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_pos_d   = rsp_pos_q;
    rsp_cnt_d   = rsp_cnt_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (go) begin
      rsp_valid_d = 1'b1;
      rsp_pos_d   = pos_ext[3:0];
      rsp_cnt_d   = cnt_ext[4:0];
    end
  end

  // Two-step sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dvst_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = dvst_pkg::ST_UPDATE;
        end
      end
      dvst_pkg::ST_UPDATE: begin
        if (go) begin
          state_d = dvst_pkg::ST_IDLE;
        end
      end
      default: state_d = dvst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvst_pkg::ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      key_q      <= req_i.value;
    end
    if (go) begin
      rsp_status_q <= rsp_status_d;
    end
    rsp_pos_q <= rsp_pos_d;
    rsp_cnt_q <= rsp_cnt_d;
  end

  // Row of cells; on a remove each cell at or above the hit takes its upper neighbor's word.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [CntW-1:0] KCnt = CntW'(k);
    localparam logic [IdxW-1:0] KIdx = IdxW'(k);
    dvst_pkg::cell_ctl_t         ctl;
    logic [dvst_pkg::ValueW-1:0] nxt;

    if (k == CAPACITY - 1) begin : g_last
      assign nxt = cell_value[k];
    end else begin : g_mid
      assign nxt = cell_value[k+1];
    end

    assign ctl.cmp   = accept;
    assign ctl.valid = (KCnt < count_q);
    assign ctl.shift = do_rem && (KIdx >= hit_pos);
    assign ctl.load  = do_add && (KCnt == count_q);

    dvst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_bus),
      .next_value_i (nxt),
      .value_o      (cell_value[k]),
      .hit_o        (hit[k])
    );
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.position    = rsp_pos_q;
  assign rsp_o.entries_now = rsp_cnt_q;

endmodule

// File: tb/tb.sv
// Testbench for distinct_value_set_table_unit.
// Requests come from a queue of pending items and feed the driver. A shadow copy
// of the value list predicts each response when its request is accepted. The
// monitor compares every response with the oldest prediction.
module tb;

  localparam int unsigned CAPACITY   = 16;
  localparam logic [1:0]  REQ_SPARE  = 2'd3;     // unused code, acts as lookup
  localparam int unsigned POOL_DEPTH = 24;
  localparam int unsigned CHUNK      = 100;
  localparam int unsigned N_CHUNKS   = 14;
  localparam int unsigned CYCLE_CAP  = 300000;
  localparam int unsigned IDLE_PCT   = 19;
  localparam int unsigned HOLD_AT    = 450;      // accepted requests before the long stall
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned BURST_LO   = 800;      // no idling on either side in this window
  localparam int unsigned BURST_HI   = 1000;

  typedef struct packed {
    logic [1:0]                  op;
    logic [dvst_pkg::ValueW-1:0] word;
  } set_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entries_now;
  } set_rsp_t;

  logic clk;
  logic rst_n;

  dvst_req_if req_if ();
  dvst_rsp_if rsp_if ();

  distinct_value_set_table_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list: the packed, insertion-ordered set of distinct words.
  // ---------------------------------------------------------------------------
  logic [dvst_pkg::ValueW-1:0] shadow_words [CAPACITY];
  int unsigned                 shadow_count;

  set_req_t    pending_reqs [$];
  set_rsp_t    awaited_rsps [$];
  logic [dvst_pkg::ValueW-1:0] word_pool [POOL_DEPTH];

  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_cycles;
  int unsigned status_seen [4];
  int unsigned n_full_list;   // requests accepted while the list was full
  int unsigned hold_left;
  bit          hold_done;

  // Applies one request to the shadow list and returns the response it causes.
  // The search finds the first bitwise-equal live entry; duplicate beats full.
  function automatic set_rsp_t apply_request(logic [1:0] op,
                                             logic [dvst_pkg::ValueW-1:0] word);
    set_rsp_t    rsp;
    bit          hit;
    int unsigned idx;
    hit = 1'b0;
    idx = 0;
    for (int unsigned k = 0; k < shadow_count; k++) begin
      if (!hit && shadow_words[k] == word) begin
        hit = 1'b1;
        idx = k;
      end
    end
    rsp.position = '0;
    case (op)
      dvst_pkg::REQ_ADD: begin
        if (hit) begin
          rsp.status = dvst_pkg::STAT_DUPLICATE;
        end else if (shadow_count >= CAPACITY) begin
          rsp.status = dvst_pkg::STAT_FULL;
        end else begin
          shadow_words[shadow_count] = word;
          rsp.position = shadow_count[3:0];
          shadow_count++;
          rsp.status = dvst_pkg::STAT_OK;
        end
      end
      dvst_pkg::REQ_REMOVE: begin
        if (!hit) begin
          rsp.status = dvst_pkg::STAT_ABSENT;
        end else begin
          // later entries slide down one place; the vacated top slot is dead
          for (int unsigned k = idx; k + 1 < shadow_count; k++)
            shadow_words[k] = shadow_words[k + 1];
          shadow_count--;
          rsp.position = idx[3:0];
          rsp.status = dvst_pkg::STAT_OK;
        end
      end
      default: begin
        // lookup and the spare code
        rsp.status = hit ? dvst_pkg::STAT_OK : dvst_pkg::STAT_ABSENT;
        if (hit) rsp.position = idx[3:0];
      end
    endcase
    rsp.entries_now = shadow_count[4:0];
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds valid until accepted, predicts at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    set_req_t nxt;
    bit       pause;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (shadow_count >= CAPACITY) n_full_list++;
        awaited_rsps.push_back(apply_request(req_if.req_type, req_if.value));
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        pause = ($urandom_range(99) < IDLE_PCT) &&
                !(n_accepted >= BURST_LO && n_accepted < BURST_HI);
        if (pending_reqs.size() != 0 && !pause) begin
          nxt = pending_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= nxt.op;
          req_if.value    <= nxt.word;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here, so the block backs up into req_if.
  always @(posedge clk) begin : hold_ctl
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: field-by-field compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    set_rsp_t exp_rsp;
    bit       stall;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: response with none expected: status %0d position %0d entries %0d",
                   $time, rsp_if.status, rsp_if.position, rsp_if.entries_now);
          n_errors++;
        end else begin
          exp_rsp = awaited_rsps.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_rsp.status, rsp_if.status);
            n_errors++;
          end
          if (rsp_if.position !== exp_rsp.position) begin
            $display("%0t: position mismatch: expected %0d actual %0d",
                     $time, exp_rsp.position, rsp_if.position);
            n_errors++;
          end
          if (rsp_if.entries_now !== exp_rsp.entries_now) begin
            $display("%0t: entries_now mismatch: expected %0d actual %0d",
                     $time, exp_rsp.entries_now, rsp_if.entries_now);
            n_errors++;
          end
          status_seen[exp_rsp.status]++;
        end
        n_checked++;
      end
      stall = ($urandom_range(99) < IDLE_PCT) &&
              !(n_checked >= BURST_LO && n_checked < BURST_HI);
      rsp_if.ready <= (hold_left == 0) && !stall;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_CAP) begin
      $display("%0t: timeout, %0d requests still awaiting a response", $time,
               awaited_rsps.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(logic [1:0] op, logic [dvst_pkg::ValueW-1:0] word);
    set_req_t r;
    r.op   = op;
    r.word = word;
    pending_reqs.push_back(r);
  endtask

  // Sender pause: nothing offered until every prediction has been matched.
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [dvst_pkg::ValueW-1:0] pick_word();
    if ($urandom_range(99) < 85) return word_pool[$urandom_range(POOL_DEPTH - 1)];
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned mode;
    int unsigned r;
    logic [1:0]  op;
    clk          = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = dvst_pkg::REQ_LOOKUP;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    shadow_count = 0;
    n_accepted   = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_cycles     = 0;
    n_full_list  = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // small pool so adds collide and removes hit; extremes and float oddities first
    word_pool[0] = '0;
    word_pool[1] = '1;
    word_pool[2] = 64'h8000_0000_0000_0000;   // -0.0
    word_pool[3] = 64'h7FF8_0000_0000_0000;   // quiet NaN
    word_pool[4] = 64'hFFF8_0000_0000_0000;   // negative NaN
    word_pool[5] = 64'h0000_0000_0000_0001;
    for (int unsigned i = 6; i < POOL_DEPTH; i++) word_pool[i] = {$urandom, $urandom};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-list misses, appends, duplicates, float patterns,
    // spare code, remove with shift, remove miss, re-append
    queue_req(dvst_pkg::REQ_LOOKUP, '0);                       // lookup miss on empty
    queue_req(dvst_pkg::REQ_REMOVE, '1);                       // remove miss on empty
    queue_req(dvst_pkg::REQ_ADD,    '0);
    queue_req(dvst_pkg::REQ_ADD,    '1);
    queue_req(dvst_pkg::REQ_ADD,    64'h8000_0000_0000_0000);  // -0 is not +0
    queue_req(dvst_pkg::REQ_ADD,    64'h7FF8_0000_0000_0000);
    queue_req(dvst_pkg::REQ_ADD,    '0);                       // duplicate
    queue_req(dvst_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0000);
    queue_req(REQ_SPARE,            64'h7FF8_0000_0000_0000);  // spare code finds the NaN
    queue_req(dvst_pkg::REQ_LOOKUP, 64'hFFF8_0000_0000_0000);  // other NaN pattern misses
    queue_req(dvst_pkg::REQ_REMOVE, '0);                       // head removed, rest shift
    queue_req(dvst_pkg::REQ_LOOKUP, '1);
    queue_req(dvst_pkg::REQ_REMOVE, '0);                       // remove miss
    queue_req(dvst_pkg::REQ_ADD,    '0);                       // re-append at the tail
    queue_req(dvst_pkg::REQ_REMOVE, 64'h8000_0000_0000_0000);  // middle entry
    queue_req(dvst_pkg::REQ_LOOKUP, '0);
    queue_req(REQ_SPARE,            64'h1234_5678_9ABC_DEF0);  // spare code miss
    queue_req(dvst_pkg::REQ_REMOVE, '0);                       // tail entry
    queue_req(dvst_pkg::REQ_ADD,    64'h5555_AAAA_5555_AAAA);
    drain();

    // random: chunks biased toward filling, emptying or mixing the list
    for (int unsigned c = 0; c < N_CHUNKS; c++) begin
      mode = $urandom_range(2);
      for (int unsigned i = 0; i < CHUNK; i++) begin
        r = $urandom_range(99);
        case (mode)
          0:       op = (r < 70) ? dvst_pkg::REQ_ADD :
                        (r < 80) ? dvst_pkg::REQ_REMOVE : dvst_pkg::REQ_LOOKUP;
          1:       op = (r < 15) ? dvst_pkg::REQ_ADD :
                        (r < 75) ? dvst_pkg::REQ_REMOVE : dvst_pkg::REQ_LOOKUP;
          default: op = (r < 35) ? dvst_pkg::REQ_ADD :
                        (r < 65) ? dvst_pkg::REQ_REMOVE : dvst_pkg::REQ_LOOKUP;
        endcase
        if ($urandom_range(99) < 3) op = REQ_SPARE;
        queue_req(op, pick_word());
      end
      if (c % 4 == 3) drain();
      else while (pending_reqs.size() > CHUNK / 2) @(posedge clk);
    end

    drain();
    repeat (8) @(posedge clk);

    $display("%0d requests checked: %0d ok, %0d duplicate, %0d absent, %0d list full",
             n_checked, status_seen[dvst_pkg::STAT_OK],
             status_seen[dvst_pkg::STAT_DUPLICATE],
             status_seen[dvst_pkg::STAT_ABSENT], status_seen[dvst_pkg::STAT_FULL]);
    $display("%0d requests met a full list; one %0d-cycle response stall", n_full_list,
             HOLD_LEN);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/dvst_pkg.sv
src/dvst_req_if.sv
src/dvst_rsp_if.sv
src/dvst_cell.sv
src/distinct_value_set_table_unit.sv
tb/tb.sv
